@@ rtl/bz_pkg.sv @@
// ----------------------------------------------------------------------------
// bz_pkg
// Shared constants, register map and pipeline control type for the cubic
// Bezier evaluator.
// ----------------------------------------------------------------------------
package bz_pkg;

    localparam int T_FRAC_BITS_DEF = 12;
    localparam int COORD_BITS_DEF  = 10;

    localparam int NUM_REGS   = 8;
    localparam int APB_ADDR_W = 5;   // byte address, registers at 4*i
    localparam int APB_DATA_W = 32;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_P0_X = 3'd0;
    localparam reg_idx_t REG_P0_Y = 3'd1;
    localparam reg_idx_t REG_P1_X = 3'd2;
    localparam reg_idx_t REG_P1_Y = 3'd3;
    localparam reg_idx_t REG_P2_X = 3'd4;
    localparam reg_idx_t REG_P2_Y = 3'd5;
    localparam reg_idx_t REG_P3_X = 3'd6;
    localparam reg_idx_t REG_P3_Y = 3'd7;

    // control travelling alongside each pipeline level
    typedef struct packed {
        logic valid;
        logic at_end;
    } stage_ctrl_t;

endpackage

@@ rtl/bz_cell.sv @@
// ----------------------------------------------------------------------------
// bz_cell
// One exact lerp cell: a*(1-t) + b*t, registered. Adds F fraction bits.
// ----------------------------------------------------------------------------
module bz_cell #(
    parameter int W = 10,
    parameter int F = 12
) (
    input  logic           aclk,
    input  logic           load,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    input  logic [F:0]     t,
    output logic [W+F-1:0] q
);

    localparam logic [F:0] T_ONE = (F+1)'(1) << F;

    logic [F:0]     t_comp;
    logic [W+F:0]   prod_a;
    logic [W+F:0]   prod_b;
    logic [W+F:0]   lerp_sum;
    logic [W+F-1:0] lerp_reg;

    always_comb begin
        t_comp   = T_ONE - t;
        prod_a   = a * t_comp;
        prod_b   = b * t;
        lerp_sum = prod_a + prod_b;
    end

    // convex combination: result never exceeds W+F bits
    always_ff @(posedge aclk) begin
        if (load) begin
            lerp_reg <= lerp_sum[W+F-1:0];
        end
    end

    assign q = lerp_reg;

endmodule

@@ rtl/bz_level.sv @@
// ----------------------------------------------------------------------------
// bz_level
// One de Casteljau level: a row of N lerp cells per axis with its own
// valid register and ready chain.
// ----------------------------------------------------------------------------
module bz_level
    import bz_pkg::*;
#(
    parameter int W = 10,
    parameter int F = 12,
    parameter int N = 3
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  stage_ctrl_t                   in_ctrl,
    input  logic [F:0]                    in_t,
    input  logic [1:0][N:0][W-1:0]        in_pts,
    output logic                          in_ready,
    output stage_ctrl_t                   out_ctrl,
    output logic [F:0]                    out_t,
    output logic [1:0][N-1:0][W+F-1:0]    out_pts,
    input  logic                          out_ready
);

    stage_ctrl_t ctrl_reg;
    logic [F:0]  t_reg;
    logic        load;

    assign in_ready = !ctrl_reg.valid || out_ready;
    assign load     = in_ctrl.valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (in_ready) begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            t_reg <= in_t;
        end
    end

    for (genvar ax = 0; ax < 2; ax++) begin : g_axis
        for (genvar k = 0; k < N; k++) begin : g_cell
            bz_cell #(
                .W (W),
                .F (F)
            ) u_cell (
                .aclk (aclk),
                .load (load),
                .a    (in_pts[ax][k]),
                .b    (in_pts[ax][k+1]),
                .t    (in_t),
                .q    (out_pts[ax][k])
            );
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_t    = t_reg;

endmodule

@@ rtl/bezier_de_casteljau_eval_core.sv @@
// ----------------------------------------------------------------------------
// bezier_de_casteljau_eval_core
// Cubic Bezier point evaluator, de Casteljau scheme, one point per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Each request carries a curve parameter t in unsigned Q1.F (2^F is 1.0;
// anything above saturates to 1.0) and produces one point, x and y rounded
// to the nearest pixel (ties upward), with tlast set for the end point at
// t = 1.0. The four control points sit in APB registers p0_x .. p3_y at byte
// addresses 0, 4, .. 28; they are to be written only while no request is
// in flight. The pipe is four registers deep: three registered interpolation
// levels (three, two, then one lerp per axis, each a row of multiply-add
// cells) and a rounding/output register. A request passes through the
// three levels and then the output register before m_tvalid rises.
// Throughput is one request per cycle; the pipeline only holds off s_tready
// when every stage is full and the output is stalled. All arithmetic is
// exact until the final rounding, so intermediate widths grow by F bits per
// level.
// ----------------------------------------------------------------------------
module bezier_de_casteljau_eval_core
    import bz_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    localparam int S_W = ((T_FRAC_BITS + 1 + 7) / 8) * 8,
    localparam int M_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_W-1:0]        s_tdata,   // [T_FRAC_BITS:0] t_value, rest zero

    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_W-1:0]        m_tdata,   // point_x, then point_y, rest zero
    output logic                  m_tlast,   // at_end

    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int F = T_FRAC_BITS;
    localparam int C = COORD_BITS;
    localparam logic [F:0] T_ONE = (F+1)'(1) << F;
    localparam logic [C+3*F-1:0] ROUND_HALF = (C+3*F)'(1) << (3*F - 1);

    // ---------------------------------------------------------------- config
    logic [C-1:0] cfg_reg [NUM_REGS];
    reg_idx_t     cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];
    assign prdata  = APB_DATA_W'(cfg_reg[cfg_idx]);

    // low COORD_BITS of the write data are kept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= '0;
            end
        end else if (psel && penable && pwrite && pready) begin
            cfg_reg[cfg_idx] <= pwdata[C-1:0];
        end
    end

    // control points per axis (x = 0, y = 1)
    logic [1:0][3:0][C-1:0] ctrl_pts;

    always_comb begin
        ctrl_pts[0][0] = cfg_reg[REG_P0_X];
        ctrl_pts[0][1] = cfg_reg[REG_P1_X];
        ctrl_pts[0][2] = cfg_reg[REG_P2_X];
        ctrl_pts[0][3] = cfg_reg[REG_P3_X];
        ctrl_pts[1][0] = cfg_reg[REG_P0_Y];
        ctrl_pts[1][1] = cfg_reg[REG_P1_Y];
        ctrl_pts[1][2] = cfg_reg[REG_P2_Y];
        ctrl_pts[1][3] = cfg_reg[REG_P3_Y];
    end

    // --------------------------------------------------------- input / sat
    logic [F:0]  t_in;
    logic [F:0]  t_sat;
    stage_ctrl_t s_ctrl;

    assign t_in          = s_tdata[F:0];
    assign s_ctrl.valid  = s_tvalid;
    assign s_ctrl.at_end = (t_in >= T_ONE);
    assign t_sat         = s_ctrl.at_end ? T_ONE : t_in;

    // ------------------------------------------------------ lerp levels
    stage_ctrl_t               l1_ctrl, l2_ctrl, l3_ctrl;
    logic [F:0]                l1_t, l2_t, l3_t;
    logic [1:0][2:0][C+F-1:0]  l1_pts;
    logic [1:0][1:0][C+2*F-1:0] l2_pts;
    logic [1:0][0:0][C+3*F-1:0] l3_pts;
    logic                      l2_ready, l3_ready, out_ready;

    bz_level #(.W(C), .F(F), .N(3)) u_level1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctrl   (s_ctrl),
        .in_t      (t_sat),
        .in_pts    (ctrl_pts),
        .in_ready  (s_tready),
        .out_ctrl  (l1_ctrl),
        .out_t     (l1_t),
        .out_pts   (l1_pts),
        .out_ready (l2_ready)
    );

    bz_level #(.W(C+F), .F(F), .N(2)) u_level2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctrl   (l1_ctrl),
        .in_t      (l1_t),
        .in_pts    (l1_pts),
        .in_ready  (l2_ready),
        .out_ctrl  (l2_ctrl),
        .out_t     (l2_t),
        .out_pts   (l2_pts),
        .out_ready (l3_ready)
    );

    bz_level #(.W(C+2*F), .F(F), .N(1)) u_level3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctrl   (l2_ctrl),
        .in_t      (l2_t),
        .in_pts    (l2_pts),
        .in_ready  (l3_ready),
        .out_ctrl  (l3_ctrl),
        .out_t     (l3_t),
        .out_pts   (l3_pts),
        .out_ready (out_ready)
    );

    // ------------------------------------------------ rounding / output
    // (v + 2^(3F-1)) >> 3F; cannot overflow as v <= (2^C - 1) * 2^3F
    logic [C+3*F-1:0] rnd_x, rnd_y;
    logic [M_W-1:0]   m_tdata_next;
    logic [M_W-1:0]   m_tdata_reg;
    logic             m_tvalid_reg;
    logic             m_tlast_reg;

    always_comb begin
        rnd_x        = l3_pts[0][0] + ROUND_HALF;
        rnd_y        = l3_pts[1][0] + ROUND_HALF;
        m_tdata_next = '0;
        m_tdata_next[C-1:0]   = rnd_x[C+3*F-1:3*F];
        m_tdata_next[2*C-1:C] = rnd_y[C+3*F-1:3*F];
    end

    assign out_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_ready) begin
            m_tvalid_reg <= l3_ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && l3_ctrl.valid) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= l3_ctrl.at_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------- assertions
    // input only backs up when the whole pipe is full and the output stalls
    a_backpressure_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("s_tready low without a stalled output");

    // a free output means the ready chain reaches the input
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("ready chain broken");

    // end flag travels with a saturated t
    a_end_t_level1: assert property (@(posedge aclk) disable iff (!aresetn)
        (l1_ctrl.valid && l1_ctrl.at_end) |-> (l1_t == T_ONE))
        else $error("end flag without t = 1.0 at level one");

    a_end_t_level3: assert property (@(posedge aclk) disable iff (!aresetn)
        (l3_ctrl.valid && l3_ctrl.at_end) |-> (l3_t == T_ONE))
        else $error("end flag without t = 1.0 at level three");

endmodule

@@ sim/bezier_de_casteljau_eval_core_tb.sv @@
// ----------------------------------------------------------------------------
// bezier_de_casteljau_eval_core_tb
// Self-checking bench for the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
// A short table of directed requests comes first: reset control points, the
// all-ones curve, a zig-zag curve and an uneven one. The t values cover zero,
// one, the last step below one, and values above one that saturate. The
// random part follows in three pacing phases, with fresh control points
// loaded over APB between chunks while the pipeline is empty. Each write is
// read back. Every result is checked field by field against a hand-worked
// answer or an in-bench model of the three-level lerp with one final rounding.
// ----------------------------------------------------------------------------
module bezier_de_casteljau_eval_core_tb;
    import bz_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TF = T_FRAC_BITS_DEF;
    localparam int CW = COORD_BITS_DEF;
    localparam longint unsigned T_ONE = 64'd1 << TF;
    localparam longint unsigned RND_HALF = 64'd1 << (3 * TF - 1);

    localparam int CHUNKS_PER_PHASE = 5;
    localparam int ITEMS_PER_CHUNK  = 130;
    localparam int HOLD_AT          = 1500;   // request count that starts the long stall
    localparam int HOLD_CYCLES      = 300;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          at_end;
    } curve_point_t;

    // one directed request: which control point set, t, and an optional
    // hand-worked answer (lit = 0 leaves it to the model)
    typedef struct {
        int            pts;
        logic [TF:0]   t;
        bit            lit;
        curve_point_t  want;
    } dir_row_t;

    // ------------------------------------------------------------------------
    // DUT signals, inputs at known values from time zero
    // ------------------------------------------------------------------------
    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata  = '0;   // [12:0] t_value, [15:13] zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;         // [9:0] point_x, [19:10] point_y, [23:20] zero
    logic                  m_tlast;         // at_end
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bezier_de_casteljau_eval_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 8 ns clock
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic [CW-1:0] ctrl_pts [NUM_REGS];    // bench copy of the control registers
    curve_point_t  pending_points [$];     // points owed by the DUT, oldest first
    int            err_cnt     = 0;
    int            items_sent  = 0;
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    int            hold_left   = 0;
    bit            hold_done   = 1'b0;

    // control point sets for the directed table, order p0x p0y p1x p1y .. p3y;
    // set 0 is the reset state and is never written
    logic [CW-1:0] point_sets [4][NUM_REGS] = '{
        '{10'd0,    10'd0,    10'd0,    10'd0,    10'd0, 10'd0,    10'd0,    10'd0},
        '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023},
        '{10'd0,    10'd1023, 10'd1023, 10'd0,    10'd0, 10'd1023, 10'd1023, 10'd0},
        '{10'd100,  10'd900,  10'd1023, 10'd1023, 10'd0, 10'd0,    10'd900,  10'd100}
    };

    dir_row_t dir_rows [22] = '{
        // reset registers: every point sits at the origin
        '{0, 13'd0,    1, '{10'd0,    10'd0,    1'b0}},
        '{0, 13'd2048, 1, '{10'd0,    10'd0,    1'b0}},
        '{0, 13'd4096, 1, '{10'd0,    10'd0,    1'b1}},
        '{0, 13'd8191, 1, '{10'd0,    10'd0,    1'b1}},
        // all control points at the far corner, written with junk upper bits
        '{1, 13'd0,    1, '{10'd1023, 10'd1023, 1'b0}},
        '{1, 13'd1,    1, '{10'd1023, 10'd1023, 1'b0}},
        '{1, 13'd4095, 1, '{10'd1023, 10'd1023, 1'b0}},
        '{1, 13'd4096, 1, '{10'd1023, 10'd1023, 1'b1}},
        '{1, 13'd4097, 1, '{10'd1023, 10'd1023, 1'b1}},
        '{1, 13'd8191, 1, '{10'd1023, 10'd1023, 1'b1}},
        // zig-zag: ends at p0 and p3, midpoint is an exact tie at 511.5
        '{2, 13'd0,    1, '{10'd0,    10'd1023, 1'b0}},
        '{2, 13'd4096, 1, '{10'd1023, 10'd0,    1'b1}},
        '{2, 13'd2048, 1, '{10'd512,  10'd512,  1'b0}},
        '{2, 13'd1,    0, '{10'd0,    10'd0,    1'b0}},
        '{2, 13'd4095, 0, '{10'd0,    10'd0,    1'b0}},
        '{2, 13'd6000, 1, '{10'd1023, 10'd0,    1'b1}},
        '{2, 13'd4097, 1, '{10'd1023, 10'd0,    1'b1}},
        // uneven curve
        '{3, 13'd0,    1, '{10'd100,  10'd900,  1'b0}},
        '{3, 13'd1,    0, '{10'd0,    10'd0,    1'b0}},
        '{3, 13'd1024, 0, '{10'd0,    10'd0,    1'b0}},
        '{3, 13'd3072, 0, '{10'd0,    10'd0,    1'b0}},
        '{3, 13'd4096, 1, '{10'd900,  10'd100,  1'b1}}
    };

    // ------------------------------------------------------------------------
    // Model: three levels of exact lerps, one round-half-up at the end
    // ------------------------------------------------------------------------
    function automatic logic [CW-1:0] bezier_axis(input longint unsigned c0,
                                                  input longint unsigned c1,
                                                  input longint unsigned c2,
                                                  input longint unsigned c3,
                                                  input longint unsigned t);
        longint unsigned u, a1, b1, d1, a2, b2, v;
        u  = T_ONE - t;
        a1 = c0 * u + c1 * t;            // F fraction bits
        b1 = c1 * u + c2 * t;
        d1 = c2 * u + c3 * t;
        a2 = a1 * u + b1 * t;            // 2F
        b2 = b1 * u + d1 * t;
        v  = a2 * u + b2 * t;            // 3F
        return CW'((v + RND_HALF) >> (3 * TF));
    endfunction

    function automatic curve_point_t eval_curve_point(input logic [TF:0] t_in);
        curve_point_t    pt;
        longint unsigned t;
        pt.at_end = (t_in >= T_ONE);     // anything from 1.0 up saturates
        t = pt.at_end ? T_ONE : longint'(t_in);
        pt.x = bezier_axis(64'(ctrl_pts[REG_P0_X]), 64'(ctrl_pts[REG_P1_X]),
                           64'(ctrl_pts[REG_P2_X]), 64'(ctrl_pts[REG_P3_X]), t);
        pt.y = bezier_axis(64'(ctrl_pts[REG_P0_Y]), 64'(ctrl_pts[REG_P1_Y]),
                           64'(ctrl_pts[REG_P2_Y]), 64'(ctrl_pts[REG_P3_Y]), t);
        return pt;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // APB access: setup phase, then access until pready, then idle to end the cycle
    // ------------------------------------------------------------------------
    task automatic apb_access(input reg_idx_t idx, input bit wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // read data is valid in the access phase
        if (!wr && prdata !== {{(APB_DATA_W-CW){1'b0}}, ctrl_pts[idx]})
            note_mismatch($sformatf("readback reg %0d", idx), int'(prdata),
                          int'(ctrl_pts[idx]));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // write all eight registers with random upper bits, which must be dropped,
    // then read each one back
    task automatic load_points(input logic [CW-1:0] vals [NUM_REGS]);
        logic [31:0] data;
        for (int i = 0; i < NUM_REGS; i++) begin
            data = ($urandom() << CW) | 32'(vals[i]);
            apb_access(reg_idx_t'(i), 1'b1, data);
            ctrl_pts[i] = vals[i];
        end
        for (int i = 0; i < NUM_REGS; i++)
            apb_access(reg_idx_t'(i), 1'b0, 32'd0);
    endtask

    // stop offering and wait for every owed point to come back
    task automatic drain_points();
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge aclk);
    endtask

    // offer one t, with random idle cycles ahead of it; records the owed
    // point at the accepting edge
    task automatic offer_t(input logic [TF:0] t, input bit lit, input curve_point_t want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {3'b000, 13'($urandom())};
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, t};
        do @(posedge aclk); while (!s_tready);
        pending_points.insert(pending_points.size(), lit ? want : eval_curve_point(t));
        items_sent++;
    endtask

    function automatic logic [TF:0] pick_t();
        case ($urandom_range(19))
            0:       return '0;
            1:       return (TF+1)'(T_ONE);
            2:       return (TF+1)'(T_ONE - 1);
            3:       return (TF+1)'($urandom_range(15));
            4, 5:    return (TF+1)'($urandom_range(8191, 4097));   // saturates
            default: return (TF+1)'($urandom_range(4096));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold once enough requests
    // have gone in, so the pipeline fills and s_tready drops
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_sent >= HOLD_AT) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: each accepted point against the oldest one owed
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        curve_point_t exp_pt;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_points.size() == 0) begin
                note_mismatch("unexpected point, x", int'(m_tdata[9:0]), 0);
            end else begin
                exp_pt = pending_points.pop_front();
                if (m_tdata[9:0] !== exp_pt.x)
                    note_mismatch("point_x", int'(m_tdata[9:0]), int'(exp_pt.x));
                if (m_tdata[19:10] !== exp_pt.y)
                    note_mismatch("point_y", int'(m_tdata[19:10]), int'(exp_pt.y));
                if (m_tlast !== exp_pt.at_end)
                    note_mismatch("at_end", int'(m_tlast), int'(exp_pt.at_end));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int            cur_set;
        logic [CW-1:0] rnd_pts [NUM_REGS];
        int            mode;

        for (int i = 0; i < NUM_REGS; i++)
            ctrl_pts[i] = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, paced like the first random phase
        tx_idle_pct = 35;
        rx_idle_pct = 48;
        cur_set = 0;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].pts != cur_set) begin
                drain_points();
                cur_set = dir_rows[r].pts;
                load_points(point_sets[cur_set]);
            end
            offer_t(dir_rows[r].t, dir_rows[r].lit, dir_rows[r].want);
        end

        // random phases: receiver-heavy idling, sender-heavy, then none
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       begin tx_idle_pct = 35; rx_idle_pct = 48; end
                1:       begin tx_idle_pct = 48; rx_idle_pct = 35; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (int ch = 0; ch < CHUNKS_PER_PHASE; ch++) begin
                drain_points();
                mode = $urandom_range(5);
                for (int i = 0; i < NUM_REGS; i++) begin
                    case (mode)
                        0:       rnd_pts[i] = '0;
                        1:       rnd_pts[i] = '1;
                        default: case ($urandom_range(3))
                                     0:       rnd_pts[i] = '0;
                                     1:       rnd_pts[i] = '1;
                                     default: rnd_pts[i] = CW'($urandom());
                                 endcase
                    endcase
                end
                load_points(rnd_pts);
                for (int k = 0; k < ITEMS_PER_CHUNK; k++)
                    offer_t(pick_t(), 1'b0, '0);
            end
        end

        // let the pipeline empty, then wait for any stray output
        drain_points();
        repeat (8) @(posedge aclk);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
